/* rtl/rvb_pkg.sv */
// Shared types, constants and arithmetic helpers for the stereo comb/allpass reverb.
// Used by rvb_mac, rvb_core and stereo_comb_allpass_reverb.
`timescale 1ns / 1ps
package rvb_pkg;

	localparam int SampleWidth = 16;
	localparam int NumCombs = 8;
	localparam int NumAllpasses = 4;
	localparam int CombTotal = 11024;
	localparam int ApTotal = 1563;
	localparam int CombAddrW = 15;
	localparam int ApAddrW = 12;
	localparam int CombPosW = 11;
	localparam int ApPosW = 10;
	localparam int AccW = 44;
	localparam int ClearLast = 2 * CombTotal - 1;

	localparam logic [CombPosW-1:0] CombLen [NumCombs] = '{
		11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617};
	localparam logic [CombAddrW-1:0] CombBase [NumCombs] = '{
		15'd0, 15'd1116, 15'd2304, 15'd3581, 15'd4937, 15'd6359, 15'd7850, 15'd9407};
	localparam logic [ApPosW-1:0] ApLen [NumAllpasses] = '{10'd225, 10'd341, 10'd441, 10'd556};
	localparam logic [ApAddrW-1:0] ApBase [NumAllpasses] = '{12'd0, 12'd225, 12'd566, 12'd1007};

	typedef enum logic [2:0] {
		REG_MONO = 3'd0,
		REG_FREEZE = 3'd1,
		REG_ROOM = 3'd2,
		REG_DAMP = 3'd3,
		REG_WET = 3'd4,
		REG_DRY = 3'd5,
		REG_INGAIN = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic        mono_mode;
		logic        freeze;
		logic [15:0] room_feedback;
		logic [15:0] damping;
		logic [15:0] wet_gain;
		logic [15:0] dry_gain;
		logic [15:0] input_gain;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic load;
	} mac_ctrl_t;

	function automatic logic signed [AccW-1:0] rnd_shr(input logic signed [AccW-1:0] v,
		input int unsigned sh);
		logic signed [AccW-1:0] half;
		half = 44'sd1 <<< (sh - 1);
		return (v + half) >>> sh;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [AccW-1:0] v);
		if (v > 44'sd8388607) begin
			return 24'sh7fffff;
		end else if (v < -44'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [AccW-1:0] v);
		if (v > 44'sd32767) begin
			return 16'sh7fff;
		end else if (v < -44'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

/* rtl/rvb_mac.sv */
// Shared multiply-accumulate unit: signed 25-bit by unsigned 17-bit into a 44-bit accumulator.
// Depends on rvb_pkg.
`timescale 1ns / 1ps
module rvb_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rvb_pkg::mac_ctrl_t            ctrl,
	input  logic signed [24:0]            a,
	input  logic [16:0]                   b,
	output logic signed [rvb_pkg::AccW-1:0] acc
);
	import rvb_pkg::*;

	logic signed [42:0] prod;
	logic signed [AccW-1:0] acc_q;

	assign prod = a * $signed({1'b0, b});
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.en) begin
			if (ctrl.load) begin
				acc_q <= AccW'(prod);
			end else begin
				acc_q <= acc_q + AccW'(prod);
			end
		end
	end
endmodule

/* rtl/rvb_core.sv */
// Reverb sequencer: delay memories, comb/allpass state and the per-frame step sequence.
// Depends on rvb_pkg and rvb_mac.
`timescale 1ns / 1ps
module rvb_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rvb_pkg::cfg_t            cfg,
	input  logic                     start,
	input  logic signed [15:0]       left_x,
	input  logic signed [15:0]       right_x,
	input  logic                     slot_free,
	output logic                     busy,
	output logic                     done,
	output logic signed [15:0]       left_y,
	output logic signed [15:0]       right_y
);
	import rvb_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_IN_M, S_IN_R, S_C_RD, S_C_M1, S_C_M2, S_C_M3, S_C_M4, S_C_WR,
		S_A_RD, S_A_WR, S_O_M1, S_O_M2, S_O_R, S_DONE
	} state_t;

	state_t state_q;
	logic [CombAddrW-1:0] clr_q;
	logic ch_q;
	logic [2:0] ci_q;
	logic [1:0] ai_q;
	logic signed [15:0] xl_q, xr_q, yl_q, yr_q;
	logic signed [24:0] in_q;
	logic signed [27:0] sum_q;
	logic signed [23:0] rev_q, f_q;
	logic [CombPosW-1:0] cpos_q [2*NumCombs];
	logic [ApPosW-1:0] apos_q [2*NumAllpasses];
	logic signed [23:0] lp_q [2*NumCombs];

	logic signed [23:0] comb_mem [2*CombTotal];
	logic signed [23:0] ap_mem [2*ApTotal];
	logic signed [23:0] crd_q, ard_q;

	logic [16:0] fb, d1, d2, g;
	logic signed [15:0] x;
	logic [3:0] cidx;
	logic [2:0] aidx;
	logic [CombPosW-1:0] cpos;
	logic [ApPosW-1:0] apos;
	logic [CombAddrW-1:0] caddr;
	logic [ApAddrW-1:0] aaddr;
	logic comb_we, ap_we;
	logic [CombAddrW-1:0] comb_wa;
	logic [ApAddrW-1:0] ap_wa;
	logic signed [23:0] comb_wd, ap_wd;
	mac_ctrl_t mctl;
	logic signed [24:0] ma;
	logic [16:0] mb;
	logic signed [AccW-1:0] acc;

	assign fb = cfg.freeze ? 17'h10000 : {1'b0, cfg.room_feedback};
	assign d1 = cfg.freeze ? 17'd0 : {1'b0, cfg.damping};
	assign d2 = 17'h10000 - d1;
	assign g = cfg.freeze ? 17'd0 : {1'b0, cfg.input_gain};
	assign x = ch_q ? xr_q : xl_q;
	assign cidx = {ch_q, ci_q};
	assign aidx = {ch_q, ai_q};
	assign cpos = cpos_q[cidx];
	assign apos = apos_q[aidx];
	assign caddr = CombBase[ci_q] + (ch_q ? CombAddrW'(CombTotal) : '0) + CombAddrW'(cpos);
	assign aaddr = ApBase[ai_q] + (ch_q ? ApAddrW'(ApTotal) : '0) + ApAddrW'(apos);

	always_comb begin
		mctl = '{en: 1'b0, load: 1'b1};
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_IN_M: begin
				mctl.en = 1'b1;
				ma = 25'(x);
				mb = g;
			end
			S_C_M1: begin
				mctl.en = 1'b1;
				ma = 25'(crd_q);
				mb = d2;
			end
			S_C_M2: begin
				mctl = '{en: 1'b1, load: 1'b0};
				ma = 25'(lp_q[cidx]);
				mb = d1;
			end
			S_C_M4: begin
				mctl.en = 1'b1;
				ma = 25'(f_q);
				mb = fb;
			end
			S_O_M1: begin
				mctl.en = 1'b1;
				ma = 25'(x) <<< 8;
				mb = {1'b0, cfg.dry_gain};
			end
			S_O_M2: begin
				mctl = '{en: 1'b1, load: 1'b0};
				ma = 25'(rev_q);
				mb = {1'b0, cfg.wet_gain};
			end
			default: begin
			end
		endcase
	end

	rvb_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (mctl),
		.a     (ma),
		.b     (mb),
		.acc   (acc)
	);

	always_comb begin
		comb_we = 1'b0;
		comb_wa = caddr;
		comb_wd = sat24(AccW'(in_q) + rnd_shr(acc, 16));
		ap_we = 1'b0;
		ap_wa = aaddr;
		ap_wd = sat24(AccW'(rev_q) + rnd_shr(AccW'(ard_q), 1));
		if (state_q == S_CLR) begin
			comb_we = 1'b1;
			comb_wa = clr_q;
			comb_wd = '0;
			ap_we = (clr_q < CombAddrW'(2 * ApTotal));
			ap_wa = clr_q[ApAddrW-1:0];
			ap_wd = '0;
		end else if (state_q == S_C_WR) begin
			comb_we = 1'b1;
		end else if (state_q == S_A_WR) begin
			ap_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (comb_we) begin
			comb_mem[comb_wa] <= comb_wd;
		end
		if (state_q == S_C_RD) begin
			crd_q <= comb_mem[caddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ap_we) begin
			ap_mem[ap_wa] <= ap_wd;
		end
		if (state_q == S_A_RD) begin
			ard_q <= ap_mem[aaddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			ch_q <= 1'b0;
			ci_q <= '0;
			ai_q <= '0;
			for (int k = 0; k < 2 * NumCombs; k++) begin
				cpos_q[k] <= '0;
				lp_q[k] <= '0;
			end
			for (int k = 0; k < 2 * NumAllpasses; k++) begin
				apos_q[k] <= '0;
			end
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CombAddrW'(ClearLast)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						xl_q <= left_x;
						xr_q <= right_x;
						ch_q <= 1'b0;
						state_q <= S_IN_M;
					end
				end
				S_IN_M: begin
					sum_q <= '0;
					ci_q <= '0;
					ai_q <= '0;
					state_q <= S_IN_R;
				end
				S_IN_R: begin
					in_q <= 25'(rnd_shr(acc, 8));
					state_q <= S_C_RD;
				end
				S_C_RD: state_q <= S_C_M1;
				S_C_M1: begin
					sum_q <= sum_q + 28'(crd_q);
					state_q <= S_C_M2;
				end
				S_C_M2: state_q <= S_C_M3;
				S_C_M3: begin
					f_q <= sat24(rnd_shr(acc, 16));
					lp_q[cidx] <= sat24(rnd_shr(acc, 16));
					state_q <= S_C_M4;
				end
				S_C_M4: state_q <= S_C_WR;
				S_C_WR: begin
					cpos_q[cidx] <= (cpos == CombLen[ci_q] - 1'b1) ? '0 : cpos + 1'b1;
					ci_q <= ci_q + 1'b1;
					if (ci_q == 3'(NumCombs - 1)) begin
						rev_q <= sat24(AccW'(sum_q));
						state_q <= S_A_RD;
					end else begin
						state_q <= S_C_RD;
					end
				end
				S_A_RD: state_q <= S_A_WR;
				S_A_WR: begin
					rev_q <= sat24(AccW'(ard_q) - AccW'(rev_q));
					apos_q[aidx] <= (apos == ApLen[ai_q] - 1'b1) ? '0 : apos + 1'b1;
					ai_q <= ai_q + 1'b1;
					state_q <= (ai_q == 2'(NumAllpasses - 1)) ? S_O_M1 : S_A_RD;
				end
				S_O_M1: state_q <= S_O_M2;
				S_O_M2: state_q <= S_O_R;
				S_O_R: begin
					if (!ch_q) begin
						yl_q <= sat16(rnd_shr(acc, 22));
						yr_q <= sat16(rnd_shr(acc, 22));
					end else begin
						yr_q <= sat16(rnd_shr(acc, 22));
					end
					if (!ch_q && !cfg.mono_mode) begin
						ch_q <= 1'b1;
						state_q <= S_IN_M;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE) && slot_free;
	assign left_y = yl_q;
	assign right_y = yr_q;

`ifndef SYNTH
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> state_q == S_IDLE) else $error("done did not return to idle");
	a_comb_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_C_RD |-> caddr < CombAddrW'(2 * CombTotal))
		else $error("comb address out of range");
	a_ap_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_RD |-> aaddr < ApAddrW'(2 * ApTotal))
		else $error("allpass address out of range");
	a_last_comb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_C_WR && ci_q == 3'(NumCombs - 1) |=> state_q == S_A_RD)
		else $error("comb loop did not hand over to allpass");
`endif
endmodule

/* rtl/stereo_comb_allpass_reverb.sv */
// Top level of the stereo comb/allpass reverb: configuration registers and result register.
// Depends on rvb_pkg and rvb_core.
`timescale 1ns / 1ps
// Each channel of a frame runs these steps, products on the shared multiply-accumulate unit:
// input gain (product, round), then per comb read, two damping products, round, feedback
// product and write over eight combs, per allpass read and write over four, and the output
// mix (dry product, wet product, round). A stereo frame runs both channels, a mono frame the
// left channel only. After reset a clearing pass zeroes the delay memories; in_stall stays
// high meanwhile, while configuration writes are taken at any time. The comb and allpass
// memories each take one read or one write per cycle.
module stereo_comb_allpass_reverb (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] left_in,
	input  logic signed [15:0] right_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import rvb_pkg::*;

	cfg_t cfg_q;
	logic out_valid_q;
	logic signed [15:0] left_q, right_q;
	logic busy, done, slot_free;
	logic signed [15:0] left_y, right_y;

	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mono_mode: 1'b0, freeze: 1'b0, room_feedback: 16'd55050,
				damping: 16'd13107, wet_gain: 16'd16384, dry_gain: 16'd0,
				input_gain: 16'd983};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MONO: cfg_q.mono_mode <= cfg_data[0];
				REG_FREEZE: cfg_q.freeze <= cfg_data[0];
				REG_ROOM: cfg_q.room_feedback <= cfg_data;
				REG_DAMP: cfg_q.damping <= cfg_data;
				REG_WET: cfg_q.wet_gain <= cfg_data;
				REG_DRY: cfg_q.dry_gain <= cfg_data;
				REG_INGAIN: cfg_q.input_gain <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rvb_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.start    (in_valid),
		.left_x   (left_in),
		.right_x  (right_in),
		.slot_free(slot_free),
		.busy     (busy),
		.done     (done),
		.left_y   (left_y),
		.right_y  (right_y)
	);

	assign in_stall = busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			left_q <= left_y;
			right_q <= right_y;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out = left_q;
	assign right_out = right_q;
endmodule
